### design/circle_outline_pixel_generator_top_assert.svh
// assertion macros used by the circle generator checker
`ifndef CIRCLE_OUTLINE_PIXEL_GENERATOR_TOP_ASSERT_SVH
`define CIRCLE_OUTLINE_PIXEL_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication, quiet while reset is held
`define CIRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is held
`define CIRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/circ_pkg.sv
package circ_pkg;

    localparam int DEF_COORD_BITS = 12;
    localparam int COLOR_BITS     = 32;
    localparam int MAX_PIX        = 8;
    localparam int PIX_IDX_BITS   = 3;

    // action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // decision constants
    localparam int DEC_INIT   = 3;
    localparam int DEC_INC_E  = 6;
    localparam int DEC_INC_SE = 10;

    // control from the step logic to the output buffer
    typedef struct packed {
        logic load;   // a new run of words is presented
        logic eight;  // run holds eight words, otherwise four
        logic done;   // run closes the circle
    } t_load;

endpackage

### design/circ_core.sv
module circ_core #(
    parameter int COORD_BITS = circ_pkg::DEF_COORD_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_accept,
    input  logic                                   i_action,
    input  logic [COORD_BITS-1:0]                  i_center_x,
    input  logic [COORD_BITS-1:0]                  i_center_y,
    input  logic [COORD_BITS-1:0]                  i_radius,
    input  logic [circ_pkg::COLOR_BITS-1:0]        i_color,
    output circ_pkg::t_load                        o_load,
    output logic signed [COORD_BITS+1:0]           o_px [circ_pkg::MAX_PIX],
    output logic signed [COORD_BITS+1:0]           o_py [circ_pkg::MAX_PIX],
    output logic [circ_pkg::COLOR_BITS-1:0]        o_color
);

    localparam int XW = COORD_BITS + 1;
    localparam int PW = COORD_BITS + 2;
    localparam int DW = COORD_BITS + 4;
    localparam logic signed [DW-1:0] DINIT = DW'(circ_pkg::DEC_INIT);
    localparam logic signed [DW-1:0] DINC_E = DW'(circ_pkg::DEC_INC_E);
    localparam logic signed [DW-1:0] DINC_SE = DW'(circ_pkg::DEC_INC_SE);

    logic [COORD_BITS-1:0]           r_cx, r_cy;
    logic [circ_pkg::COLOR_BITS-1:0] r_color;
    logic [XW-1:0]                   r_x, r_y;
    logic signed [DW-1:0]            r_dec;
    logic                            r_busy;

    logic                  w_start, w_diag, w_rad_zero;
    logic [COORD_BITS-1:0] w_cx, w_cy;
    logic signed [PW-1:0]  w_sx, w_sy, w_sr, w_cxe, w_cye, w_zero;
    logic signed [PW-1:0]  w_ox [circ_pkg::MAX_PIX];
    logic signed [PW-1:0]  w_oy [circ_pkg::MAX_PIX];
    logic signed [DW-1:0]  w_dx, w_dy, w_dr, w_dec_e, w_dec_se, w_dec_init;

    always_comb begin
        w_start    = (i_action == circ_pkg::ACT_START);
        w_rad_zero = (i_radius == '0);
        w_diag     = !(r_x < r_y);
        w_cx       = w_start ? i_center_x : r_cx;
        w_cy       = w_start ? i_center_y : r_cy;
        w_cxe      = $signed({2'b00, w_cx});
        w_cye      = $signed({2'b00, w_cy});
        w_sx       = $signed({1'b0, r_x});
        w_sy       = $signed({1'b0, r_y});
        w_sr       = $signed({2'b00, i_radius});
        w_zero     = '0;
        w_dx       = $signed({{(DW-XW){1'b0}}, r_x});
        w_dy       = $signed({{(DW-XW){1'b0}}, r_y});
        w_dr       = $signed({{(DW-COORD_BITS){1'b0}}, i_radius});
        w_dec_e    = r_dec + (w_dx <<< 2) + DINC_E;
        w_dec_se   = r_dec + ((w_dx - w_dy) <<< 2) + DINC_SE;
        w_dec_init = DINIT - (w_dr <<< 1);

        for (int i = 0; i < circ_pkg::MAX_PIX; i++) begin
            w_ox[i] = w_zero;
            w_oy[i] = w_zero;
        end
        if (w_start) begin
            // axis pixels
            w_oy[0] = w_sr;
            w_oy[1] = -w_sr;
            w_ox[2] = w_sr;
            w_ox[3] = -w_sr;
        end else if (w_diag) begin
            // diagonal pixels use the current y
            w_ox[0] = w_sy;  w_oy[0] = w_sy;
            w_ox[1] = w_sy;  w_oy[1] = -w_sy;
            w_ox[2] = -w_sy; w_oy[2] = -w_sy;
            w_ox[3] = -w_sy; w_oy[3] = w_sy;
        end else begin
            w_ox[0] = w_sx;  w_oy[0] = w_sy;
            w_ox[1] = w_sx;  w_oy[1] = -w_sy;
            w_ox[2] = -w_sx; w_oy[2] = -w_sy;
            w_ox[3] = -w_sx; w_oy[3] = w_sy;
            w_ox[4] = w_sy;  w_oy[4] = w_sx;
            w_ox[5] = w_sy;  w_oy[5] = -w_sx;
            w_ox[6] = -w_sy; w_oy[6] = -w_sx;
            w_ox[7] = -w_sy; w_oy[7] = w_sx;
        end
        for (int i = 0; i < circ_pkg::MAX_PIX; i++) begin
            o_px[i] = w_cxe + w_ox[i];
            o_py[i] = w_cye + w_oy[i];
        end

        o_color = w_start ? i_color : r_color;
        if (w_start) begin
            o_load.load  = i_accept && !w_rad_zero;
            o_load.eight = 1'b0;
            o_load.done  = 1'b0;
        end else begin
            o_load.load  = i_accept && r_busy;
            o_load.eight = !w_diag;
            o_load.done  = w_diag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= '0;
            r_cy    <= '0;
            r_color <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_dec   <= '0;
            r_busy  <= 1'b0;
        end else if (i_accept) begin
            if (w_start) begin
                r_cx    <= i_center_x;
                r_cy    <= i_center_y;
                r_color <= i_color;
                if (w_rad_zero) begin
                    r_busy <= 1'b0;
                end else begin
                    r_busy <= 1'b1;
                    r_x    <= XW'(1);
                    r_y    <= {1'b0, i_radius};
                    r_dec  <= w_dec_init;
                end
            end else if (r_busy) begin
                if (w_diag) begin
                    r_busy <= 1'b0;
                end else begin
                    r_x <= r_x + XW'(1);
                    if (r_dec < 0) begin
                        r_dec <= w_dec_e;
                    end else begin
                        r_dec <= w_dec_se;
                        r_y   <= r_y - XW'(1);
                    end
                end
            end
        end
    end

endmodule

### design/circ_emit.sv
module circ_emit #(
    parameter int COORD_BITS = circ_pkg::DEF_COORD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  circ_pkg::t_load                   i_load,
    input  logic signed [COORD_BITS+1:0]      i_px [circ_pkg::MAX_PIX],
    input  logic signed [COORD_BITS+1:0]      i_py [circ_pkg::MAX_PIX],
    input  logic [circ_pkg::COLOR_BITS-1:0]   i_color,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic signed [COORD_BITS+1:0]      o_pixel_x,
    output logic signed [COORD_BITS+1:0]      o_pixel_y,
    output logic [circ_pkg::COLOR_BITS-1:0]   o_pixel_color,
    output logic                              o_last_of_run,
    output logic                              o_circle_done,
    output logic                              o_free
);

    localparam int PW = COORD_BITS + 2;
    localparam int IW = circ_pkg::PIX_IDX_BITS;
    localparam logic [IW-1:0] LAST8 = IW'(circ_pkg::MAX_PIX - 1);
    localparam logic [IW-1:0] LAST4 = IW'(circ_pkg::MAX_PIX / 2 - 1);

    logic signed [PW-1:0]            r_px [circ_pkg::MAX_PIX];
    logic signed [PW-1:0]            r_py [circ_pkg::MAX_PIX];
    logic [circ_pkg::COLOR_BITS-1:0] r_color;
    logic [IW-1:0]                   r_idx;
    logic                            r_valid, r_eight, r_done;
    logic                            w_last, w_take;

    always_comb begin
        w_last        = (r_idx == (r_eight ? LAST8 : LAST4));
        w_take        = r_valid && !i_out_stall;
        o_out_valid   = r_valid;
        o_pixel_x     = r_px[r_idx];
        o_pixel_y     = r_py[r_idx];
        o_pixel_color = r_color;
        o_last_of_run = w_last;
        o_circle_done = w_last && r_done;
        // buffer can take a new run now or as its last word leaves
        o_free        = !r_valid || (w_take && w_last);
    end

    // run payload
    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_px    <= i_px;
            r_py    <= i_py;
            r_color <= i_color;
            r_eight <= i_load.eight;
            r_done  <= i_load.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load.load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (w_take) begin
            if (w_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

endmodule

### design/circle_outline_pixel_generator_top.sv
// circle outline pixel generator: a start word (action 0) latches center, radius and color and
// yields the four axis pixels, or nothing for a zero radius; each step word (action 1) yields the
// eight octant pixels of the current point and advances the midpoint decision, and once x has
// reached y a step yields the four diagonal pixels with circle_done set on the last one. steps
// while no circle is running are swallowed, and a start abandons any running circle. pixels
// leave one per cycle through a single output port unless i_out_stall holds them; the first pixel
// shows in the cycle after the word is taken, and the next input word is taken in the same cycle
// the last pixel of the previous one leaves
// coordinates are two's complement, COORD_BITS + 2 wide, and never wrap
module circle_outline_pixel_generator_top #(
    parameter int COORD_BITS = circ_pkg::DEF_COORD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input words
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_action,
    input  logic [COORD_BITS-1:0]             i_center_x,
    input  logic [COORD_BITS-1:0]             i_center_y,
    input  logic [COORD_BITS-1:0]             i_radius,
    input  logic [circ_pkg::COLOR_BITS-1:0]   i_color,
    // pixel words
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [COORD_BITS+1:0]      o_pixel_x,
    output logic signed [COORD_BITS+1:0]      o_pixel_y,
    output logic [circ_pkg::COLOR_BITS-1:0]   o_pixel_color,
    output logic                              o_last_of_run,
    output logic                              o_circle_done
);

    localparam int PW = COORD_BITS + 2;

    circ_pkg::t_load                 w_load;
    logic signed [PW-1:0]            w_px [circ_pkg::MAX_PIX];
    logic signed [PW-1:0]            w_py [circ_pkg::MAX_PIX];
    logic [circ_pkg::COLOR_BITS-1:0] w_color;
    logic                            w_free;
    logic                            w_accept;

    // every word waits for the pixel buffer, including ones that produce no pixels
    assign o_in_stall = !w_free;
    assign w_accept   = i_in_valid && w_free;

    // circle state and pixel computation for the word being taken
    circ_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_action   (i_action),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_color    (i_color),
        .o_load     (w_load),
        .o_px       (w_px),
        .o_py       (w_py),
        .o_color    (w_color)
    );

    // registered run of up to eight pixels, drained one word per cycle while the output is not stalled
    circ_emit #(
        .COORD_BITS (COORD_BITS)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_px          (w_px),
        .i_py          (w_py),
        .i_color       (w_color),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_of_run (o_last_of_run),
        .o_circle_done (o_circle_done),
        .o_free        (w_free)
    );

endmodule

### design/circ_chk.sv
`include "circle_outline_pixel_generator_top_assert.svh"

module circ_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_last_of_run,
    input logic o_circle_done
);

    // a circle only ends on the last pixel of a run
    `CIRC_ASSERT_NOW(a_done_is_last, i_clk, i_rst_n,
        o_out_valid && o_circle_done, o_last_of_run,
        "circle_done without last_of_run")

    // input must wait while a run still has words after the current one
    `CIRC_ASSERT_NOW(a_stall_mid_run, i_clk, i_rst_n,
        o_out_valid && !o_last_of_run, o_in_stall,
        "input taken in the middle of a run")

    // an empty output side never holds off input
    `CIRC_ASSERT_NOW(a_idle_no_stall, i_clk, i_rst_n,
        !o_out_valid, !o_in_stall,
        "input stalled with no pixel pending")

    // a stalled pixel stays offered
    `CIRC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall, o_out_valid,
        "pixel dropped while stalled")

endmodule

bind circle_outline_pixel_generator_top circ_chk u_circ_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_last_of_run (o_last_of_run),
    .o_circle_done (o_circle_done)
);

### tb/circle_outline_pixel_generator_top_test.sv
module circle_outline_pixel_generator_top_test;

    localparam int COORD_BITS  = circ_pkg::DEF_COORD_BITS;
    localparam int PIX_W       = COORD_BITS + 2;
    localparam int STEP_W      = COORD_BITS + 1;
    localparam int COL_W       = circ_pkg::COLOR_BITS;
    // run ends here even if the block hangs
    localparam int CYCLE_LIMIT = 200000;
    // length of the long receiver hold-off
    localparam int HOLD_CYCLES = 400;
    // quiet cycles after the last pixel
    localparam int DRAIN_CYCLES = 24;

    // one pixel word as seen on the output port
    typedef struct {
        logic signed [PIX_W-1:0] x;
        logic signed [PIX_W-1:0] y;
        logic [COL_W-1:0]        color;
        logic                    last;
        logic                    done;
    } pixel_t;

    // tracks the circle being drawn and the pixel words still owed
    class circle_scoreboard;
        logic [COORD_BITS-1:0]   org_x;
        logic [COORD_BITS-1:0]   org_y;
        logic [COL_W-1:0]        ink;
        logic signed [COORD_BITS:0] cur_x;
        logic signed [COORD_BITS:0] cur_y;
        logic signed [15:0]      decision;
        bit                      running;
        pixel_t                  expected_q[$];
        int                      errors;

        function new();
            org_x    = '0;
            org_y    = '0;
            ink      = '0;
            cur_x    = '0;
            cur_y    = '0;
            decision = '0;
            running  = 1'b0;
            errors   = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void plot(int dx, int dy, bit last, bit done);
            pixel_t p;
            p.x     = PIX_W'(int'(org_x) + dx);
            p.y     = PIX_W'(int'(org_y) + dy);
            p.color = ink;
            p.last  = last;
            p.done  = done;
            expected_q.push_back(p);
        endfunction

        // accepted input word: work out the pixels it must produce
        function void note_word(logic act, logic [COORD_BITS-1:0] cx,
                                logic [COORD_BITS-1:0] cy, logic [COORD_BITS-1:0] rad,
                                logic [COL_W-1:0] col);
            int x;
            int y;
            if (act == circ_pkg::ACT_START) begin
                org_x   = cx;
                org_y   = cy;
                ink     = col;
                running = (rad != 0);
                if (rad == 0)
                    return;
                y        = int'(rad);
                cur_x    = STEP_W'(1);
                cur_y    = STEP_W'(y);
                decision = 16'(circ_pkg::DEC_INIT - 2 * y);
                plot(0, y, 1'b0, 1'b0);
                plot(0, -y, 1'b0, 1'b0);
                plot(y, 0, 1'b0, 1'b0);
                plot(-y, 0, 1'b1, 1'b0);
            end else if (running) begin
                x = int'(cur_x);
                y = int'(cur_y);
                if (x < y) begin
                    plot(x, y, 1'b0, 1'b0);
                    plot(x, -y, 1'b0, 1'b0);
                    plot(-x, -y, 1'b0, 1'b0);
                    plot(-x, y, 1'b0, 1'b0);
                    plot(y, x, 1'b0, 1'b0);
                    plot(y, -x, 1'b0, 1'b0);
                    plot(-y, -x, 1'b0, 1'b0);
                    plot(-y, x, 1'b1, 1'b0);
                    if (decision < 0) begin
                        decision = 16'(int'(decision) + 4 * x + circ_pkg::DEC_INC_E);
                    end else begin
                        decision = 16'(int'(decision) + 4 * (x - y)
                                       + circ_pkg::DEC_INC_SE);
                        y--;
                    end
                    cur_x = STEP_W'(x + 1);
                    cur_y = STEP_W'(y);
                end else begin
                    plot(y, y, 1'b0, 1'b0);
                    plot(y, -y, 1'b0, 1'b0);
                    plot(-y, -y, 1'b0, 1'b0);
                    plot(-y, y, 1'b1, 1'b1);
                    running = 1'b0;
                end
            end
        endfunction

        // accepted pixel word: compare against the oldest one owed
        function void check_pixel(pixel_t got);
            pixel_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $error("pixel word with none expected: x %0d y %0d", got.x, got.y);
                return;
            end
            want = expected_q.pop_front();
            if (got.x !== want.x) begin
                errors++;
                $error("pixel_x: expected %0d, got %0d", want.x, got.x);
            end
            if (got.y !== want.y) begin
                errors++;
                $error("pixel_y: expected %0d, got %0d", want.y, got.y);
            end
            if (got.color !== want.color) begin
                errors++;
                $error("pixel_color: expected %h, got %h", want.color, got.color);
            end
            if (got.last !== want.last) begin
                errors++;
                $error("last_of_run: expected %b, got %b", want.last, got.last);
            end
            if (got.done !== want.done) begin
                errors++;
                $error("circle_done: expected %b, got %b", want.done, got.done);
            end
        endfunction
    endclass

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_in_valid    = 1'b0;
    logic                    o_in_stall;
    logic                    i_action      = circ_pkg::ACT_START;
    logic [COORD_BITS-1:0]   i_center_x    = '0;
    logic [COORD_BITS-1:0]   i_center_y    = '0;
    logic [COORD_BITS-1:0]   i_radius      = '0;
    logic [COL_W-1:0]        i_color       = '0;
    logic                    o_out_valid;
    logic                    i_out_stall   = 1'b0;
    logic signed [PIX_W-1:0] o_pixel_x;
    logic signed [PIX_W-1:0] o_pixel_y;
    logic [COL_W-1:0]        o_pixel_color;
    logic                    o_last_of_run;
    logic                    o_circle_done;

    // idle rates in percent, changed per phase
    int send_idle_pct  = 11;
    int recv_stall_pct = 50;
    // raised by the stimulus to ask the receiver for one long hold-off
    bit hold_off_req   = 1'b0;
    int cycle_count    = 0;

    circle_scoreboard board;

    circle_outline_pixel_generator_top #(
        .COORD_BITS (COORD_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius      (i_radius),
        .i_color       (i_color),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_of_run (o_last_of_run),
        .o_circle_done (o_circle_done)
    );

    // free-running clock, period 12
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // both handshakes sampled at the rising edge, before the block updates
    always @(posedge i_clk) begin
        pixel_t got;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                board.note_word(i_action, i_center_x, i_center_y, i_radius, i_color);
            if (o_out_valid && !i_out_stall) begin
                got.x     = o_pixel_x;
                got.y     = o_pixel_y;
                got.color = o_pixel_color;
                got.last  = o_last_of_run;
                got.done  = o_circle_done;
                board.check_pixel(got);
            end
        end
    end

    // pixel side: random stall at the falling edge, plus the long hold-off
    // counted here so the sender keeps pushing while the block backs up
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    i_out_stall = 1'b1;
                    @(negedge i_clk);
                end
            end
            i_out_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    // offer one input word; called and returning at a falling edge
    task automatic send_word(input logic act, input logic [COORD_BITS-1:0] cx,
                             input logic [COORD_BITS-1:0] cy,
                             input logic [COORD_BITS-1:0] rad,
                             input logic [COL_W-1:0] col);
        // sender gaps come before the word, never while it is stalled
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_action   = act;
        i_center_x = cx;
        i_center_y = cy;
        i_radius   = rad;
        i_color    = col;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // step word with junk in the fields the block ignores on a step
    task automatic send_step();
        send_word(circ_pkg::ACT_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                  COORD_BITS'($urandom), $urandom);
    endtask

    // random circles: mostly complete ones, some cut short by a new start,
    // a few zero-radius starts and stray steps
    task automatic run_random(input int word_budget);
        int  sent;
        int  pick;
        int  rad;
        int  cap;
        int  steps;
        bit  live;
        sent = 0;
        while (sent < word_budget) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                // stray step, swallowed unless a circle is still open
                live = board.running;
                send_step();
                if (live)
                    sent++;
            end else begin
                if (pick < 10)
                    rad = 0;
                else if (pick < 16)
                    rad = $urandom_range(4095);
                else
                    rad = $urandom_range(24, 1);
                // big circles are always cut short to keep the run short
                if (rad > 64)
                    cap = $urandom_range(40, 2);
                else if ($urandom_range(9) == 0)
                    cap = $urandom_range(rad);
                else
                    cap = rad + 2;
                send_word(circ_pkg::ACT_START, COORD_BITS'($urandom),
                          COORD_BITS'($urandom), COORD_BITS'(rad), $urandom);
                sent++;
                steps = 0;
                while (board.running && steps < cap) begin
                    send_step();
                    steps++;
                    sent++;
                end
            end
        end
    endtask

    initial begin
        board = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: idle steps, zero radius, radius one, extreme corners,
        // start while busy, overshoot on a small circle
        send_step();
        send_word(circ_pkg::ACT_START, 12'hfff, 12'h000, 12'd0, 32'hffff_ffff);
        send_step();
        send_word(circ_pkg::ACT_START, 12'h000, 12'h000, 12'd1, 32'h0000_0000);
        send_step();
        send_step();
        send_word(circ_pkg::ACT_START, 12'hfff, 12'hfff, 12'hfff, 32'ha5a5_a5a5);
        send_step();
        send_step();
        // abandon the corner circle for one at the origin
        send_word(circ_pkg::ACT_START, 12'h000, 12'h000, 12'hfff, 32'h5a5a_5a5a);
        send_step();
        send_step();
        // radius three: x passes y after the last decrement
        send_word(circ_pkg::ACT_START, 12'd100, 12'd200, 12'd3, $urandom);
        while (board.running)
            send_step();
        send_word(circ_pkg::ACT_START, 12'd2048, 12'd2048, 12'd2, $urandom);
        while (board.running)
            send_step();
        send_word(circ_pkg::ACT_START, 12'd1, 12'd4094, 12'd5, $urandom);
        while (board.running)
            send_step();

        // phase one: sender mostly busy, receiver stalls half the time,
        // with a long hold-off so the block fills and stalls its input
        hold_off_req = 1'b1;
        run_random(170);

        // phase two: the other way round
        send_idle_pct  = 50;
        recv_stall_pct = 11;
        run_random(170);

        // phase three: no idling on either side, one more hold-off
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 1'b1;
        run_random(160);
        i_in_valid = 1'b0;

        // drain, then give the block time to show any stray pixel
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0 && board.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### circle_outline_pixel_generator_top.f
+incdir+design
design/circ_pkg.sv
design/circ_core.sv
design/circ_emit.sv
design/circle_outline_pixel_generator_top.sv
design/circ_chk.sv
tb/circle_outline_pixel_generator_top_test.sv
